[hw/rtl/imk_pkg.sv]
// ----------------------------------------------------------------------------
// imk_pkg
// Shared types and constants of the iambic Morse keyer.
// ----------------------------------------------------------------------------
package imk_pkg;

  // configuration register file
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned DIT_W      = 12;
  localparam int unsigned WEIGHT_W   = 7;

  localparam logic [CFG_IDX_W-1:0] REG_DIT_TICKS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_B     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MID_GATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIT_MEM    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DAH_MEM    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_SPACE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_SPACE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT     = 3'd7;

  localparam logic [DIT_W-1:0]    DIT_TICKS_RST = 12'd60;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST    = 7'd50;

  // dit_ticks * weight_pct
  localparam int unsigned PROD_W = DIT_W + WEIGHT_W;
  // product / 50 is done as (product / 2) / 25 with a reciprocal multiply
  localparam int unsigned HALF_W     = PROD_W - 1;
  localparam int unsigned RECIP_SH   = 23;
  localparam int unsigned RECIP_W    = 19;
  localparam logic [RECIP_W-1:0] RECIP25 = 19'd335545;  // ceil(2^23 / 25)
  localparam int unsigned MUL_W      = HALF_W + RECIP_W;
  localparam int unsigned QUOT_W     = 14;
  // widest unsaturated time (beep of a dah)
  localparam int unsigned RAW_W      = 16;

  // keyer option flags
  typedef struct packed {
    logic mode_b;
    logic mid_gate;
    logic dit_mem;
    logic dah_mem;
    logic char_space;
    logic word_space;
  } imk_flags_t;

endpackage

[hw/rtl/iambic_morse_keyer_top.sv]
// ----------------------------------------------------------------------------
// iambic_morse_keyer_top
// Path: the tick passes three input stages, lined up with the three-stage
//   length derivation, and is then keyed into the output register.
//   Throughput: one tick per cycle unless out_ready stalls the pipeline;
//   the keyer update is combinational.
// Reset: synchronous, active low; clears registers to their reset values,
//   empties the pipeline and restarts the keyer at its first tick.
// ----------------------------------------------------------------------------
module iambic_morse_keyer_top #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_dit_paddle,
  input  logic                            in_dah_paddle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_key_down,
  input  logic                            cfg_wr_en,
  input  logic [imk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [imk_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import imk_pkg::*;

  localparam int unsigned STAGES = 3;

  logic [DIT_W-1:0]       dit_ticks_r;
  logic [WEIGHT_W-1:0]    weight_r;
  imk_flags_t             flags_r;
  logic [STAGES-1:0]      v_r;
  logic [STAGES-1:0]      dit_r;
  logic [STAGES-1:0]      dah_r;
  logic [STAGES:0]        take;
  logic                   out_valid_r;
  logic                   key_r;
  logic                   key_nxt;
  logic                   fire;
  logic [COUNT_WIDTH-1:0] beep_dit;
  logic [COUNT_WIDTH-1:0] beep_dah;
  logic [COUNT_WIDTH-1:0] mid_dit;
  logic [COUNT_WIDTH-1:0] mid_dah;
  logic [COUNT_WIDTH-1:0] len2;
  logic [COUNT_WIDTH-1:0] len4;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dit_ticks_r        <= DIT_TICKS_RST;
      weight_r           <= WEIGHT_RST;
      flags_r.mode_b     <= 1'b0;
      flags_r.mid_gate   <= 1'b0;
      flags_r.dit_mem    <= 1'b1;
      flags_r.dah_mem    <= 1'b1;
      flags_r.char_space <= 1'b0;
      flags_r.word_space <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DIT_TICKS:  dit_ticks_r        <= cfg_wdata[DIT_W-1:0];
        REG_MODE_B:     flags_r.mode_b     <= cfg_wdata[0];
        REG_MID_GATE:   flags_r.mid_gate   <= cfg_wdata[0];
        REG_DIT_MEM:    flags_r.dit_mem    <= cfg_wdata[0];
        REG_DAH_MEM:    flags_r.dah_mem    <= cfg_wdata[0];
        REG_CHAR_SPACE: flags_r.char_space <= cfg_wdata[0];
        REG_WORD_SPACE: flags_r.word_space <= cfg_wdata[0];
        REG_WEIGHT:     weight_r           <= cfg_wdata[WEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // elastic input stages: a stage takes data when empty or moving on
  always_comb begin
    take[STAGES] = !out_valid_r || out_ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      take[k] = !v_r[k] || take[k+1];
    end
  end

  assign in_ready = rst_n && take[0];
  assign fire     = v_r[STAGES-1] && take[STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (take[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (take[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take[0]) begin
      dit_r[0] <= in_dit_paddle;
      dah_r[0] <= in_dah_paddle;
    end
    for (int k = 1; k < STAGES; k++) begin
      if (take[k]) begin
        dit_r[k] <= dit_r[k-1];
        dah_r[k] <= dah_r[k-1];
      end
    end
  end

  // element and gap lengths
  imk_timing #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_timing (
    .clk        (clk),
    .dit_ticks  (dit_ticks_r),
    .weight_pct (weight_r),
    .beep_dit   (beep_dit),
    .beep_dah   (beep_dah),
    .mid_dit    (mid_dit),
    .mid_dah    (mid_dah),
    .len2       (len2),
    .len4       (len4)
  );

  // keyer state machine
  imk_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .dit      (dit_r[STAGES-1]),
    .dah      (dah_r[STAGES-1]),
    .flags    (flags_r),
    .beep_dit (beep_dit),
    .beep_dah (beep_dah),
    .mid_dit  (mid_dit),
    .mid_dah  (mid_dah),
    .len2     (len2),
    .len4     (len4),
    .key_nxt  (key_nxt)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take[STAGES]) begin
      out_valid_r <= v_r[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      key_r <= key_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key_down = key_r;

endmodule

[hw/rtl/imk_timing.sv]
// ----------------------------------------------------------------------------
// imk_timing
// Derives beep, mid-element, element and gap lengths from the dit length
// and weighting, in three register stages, saturated to the counter width.
// ----------------------------------------------------------------------------
module imk_timing #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic [imk_pkg::DIT_W-1:0]     dit_ticks,
  input  logic [imk_pkg::WEIGHT_W-1:0]  weight_pct,
  output logic [COUNT_WIDTH-1:0]        beep_dit,
  output logic [COUNT_WIDTH-1:0]        beep_dah,
  output logic [COUNT_WIDTH-1:0]        mid_dit,
  output logic [COUNT_WIDTH-1:0]        mid_dah,
  output logic [COUNT_WIDTH-1:0]        len2,
  output logic [COUNT_WIDTH-1:0]        len4
);
  import imk_pkg::*;

  localparam logic [32:0] CMAX = (33'd1 << COUNT_WIDTH) - 33'd1;

  logic [PROD_W-1:0]      prod_r;
  logic [MUL_W-1:0]       mul;
  logic [QUOT_W-1:0]      quot_r;
  logic [RAW_W-1:0]       raw_dit;
  logic [RAW_W-1:0]       raw_dah;
  logic [RAW_W-1:0]       raw2;
  logic [RAW_W-1:0]       raw4;
  logic [COUNT_WIDTH-1:0] sat_dit;
  logic [COUNT_WIDTH-1:0] sat_dah;
  logic [COUNT_WIDTH-1:0] beep_dit_r;
  logic [COUNT_WIDTH-1:0] beep_dah_r;
  logic [COUNT_WIDTH-1:0] mid_dit_r;
  logic [COUNT_WIDTH-1:0] mid_dah_r;
  logic [COUNT_WIDTH-1:0] len2_r;
  logic [COUNT_WIDTH-1:0] len4_r;

  function automatic logic [COUNT_WIDTH-1:0] sat(input logic [RAW_W-1:0] v);
    logic [32:0] wide;
    wide = {{(33-RAW_W){1'b0}}, v};
    if (wide > CMAX) begin
      sat = CMAX[COUNT_WIDTH-1:0];
    end else begin
      sat = wide[COUNT_WIDTH-1:0];
    end
  endfunction

  // reciprocal multiply, exact for every product below 2^19
  assign mul = prod_r[PROD_W-1:1] * RECIP25;

  // unsaturated lengths
  always_comb begin
    raw_dit = {{(RAW_W-QUOT_W){1'b0}}, quot_r};
    raw_dah = raw_dit + {{(RAW_W-DIT_W-1){1'b0}}, dit_ticks, 1'b0};
    raw2    = {{(RAW_W-DIT_W-1){1'b0}}, dit_ticks, 1'b0};
    raw4    = {{(RAW_W-DIT_W-2){1'b0}}, dit_ticks, 2'b00};
    sat_dit = sat(raw_dit);
    sat_dah = sat(raw_dah);
  end

  // product, quotient, saturated lengths
  always_ff @(posedge clk) begin
    prod_r     <= dit_ticks * weight_pct;
    quot_r     <= mul[RECIP_SH +: QUOT_W];
    beep_dit_r <= sat_dit;
    beep_dah_r <= sat_dah;
    mid_dit_r  <= sat_dit >> 1;
    mid_dah_r  <= sat_dah >> 1;
    len2_r     <= sat(raw2);
    len4_r     <= sat(raw4);
  end

  assign beep_dit = beep_dit_r;
  assign beep_dah = beep_dah_r;
  assign mid_dit  = mid_dit_r;
  assign mid_dah  = mid_dah_r;
  assign len2     = len2_r;
  assign len4     = len4_r;

endmodule

[hw/rtl/imk_core.sv]
// ----------------------------------------------------------------------------
// imk_core
// Keyer state and its one-tick update: element sequencing, squeeze and
// paddle memories, mode A/B completion and automatic spacing.
// ----------------------------------------------------------------------------
module imk_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    fire,
  input  logic                    dit,
  input  logic                    dah,
  input  imk_pkg::imk_flags_t     flags,
  input  logic [COUNT_WIDTH-1:0]  beep_dit,
  input  logic [COUNT_WIDTH-1:0]  beep_dah,
  input  logic [COUNT_WIDTH-1:0]  mid_dit,
  input  logic [COUNT_WIDTH-1:0]  mid_dah,
  input  logic [COUNT_WIDTH-1:0]  len2,
  input  logic [COUNT_WIDTH-1:0]  len4,
  output logic                    key_nxt
);
  import imk_pkg::*;

  typedef enum logic [1:0] {EL_NONE, EL_DIT, EL_DAH} elem_t;
  typedef enum logic [1:0] {SQ_NONE, SQ_SQUEEZED, SQ_RELEASED} squeeze_t;
  typedef enum logic [1:0] {GAP_NONE, GAP_CHAR, GAP_WORD} gap_t;
  typedef enum logic [1:0] {SCH_KEEP, SCH_CANCEL, SCH_DIT, SCH_DAH} sched_t;

  logic                   started_r;
  logic                   last_dit_r, last_dit_nxt;
  logic                   last_dah_r, last_dah_nxt;
  elem_t                  play_r, play_nxt;
  squeeze_t               sq_r, sq_nxt;
  logic                   sam_r, sam_nxt;
  logic                   ins_r, ins_nxt;
  logic [COUNT_WIDTH-1:0] mid_r, mid_nxt;
  logic [COUNT_WIDTH-1:0] beep_r, beep_nxt;
  logic [COUNT_WIDTH-1:0] elem_r, elem_nxt;
  logic [COUNT_WIDTH-1:0] gap_r, gap_nxt;
  gap_t                   kind_r, kind_nxt;
  sched_t                 sched;
  logic                   again;

  function automatic logic [COUNT_WIDTH-1:0] dec(input logic [COUNT_WIDTH-1:0] v);
    dec = (v == '0) ? '0 : v - 1'b1;
  endfunction

  // one tick of the keyer
  always_comb begin
    play_nxt     = play_r;
    sq_nxt       = sq_r;
    sam_nxt      = sam_r;
    ins_nxt      = ins_r;
    mid_nxt      = mid_r;
    beep_nxt     = beep_r;
    elem_nxt     = elem_r;
    gap_nxt      = gap_r;
    kind_nxt     = kind_r;
    last_dit_nxt = last_dit_r;
    last_dah_nxt = last_dah_r;
    sched        = SCH_KEEP;
    again        = 1'b0;

    // first tick: take paddle levels as they are
    if (!started_r) begin
      last_dit_nxt = dit;
      last_dah_nxt = dah;
      play_nxt     = EL_NONE;
      sq_nxt       = SQ_NONE;
      sam_nxt      = 1'b0;
      ins_nxt      = 1'b0;
      mid_nxt      = '0;
      beep_nxt     = '0;
      elem_nxt     = '0;
      gap_nxt      = '0;
      kind_nxt     = GAP_NONE;
    end

    // gap runs first, element timers only when no gap
    gap_nxt = dec(gap_nxt);
    if (gap_nxt == '0) begin
      if (elem_nxt == '0 && kind_nxt == GAP_CHAR && flags.word_space) begin
        gap_nxt  = len4;
        kind_nxt = GAP_WORD;
      end else begin
        kind_nxt = GAP_NONE;
        mid_nxt  = dec(mid_nxt);
        beep_nxt = dec(beep_nxt);
        elem_nxt = dec(elem_nxt);
      end
    end

    // squeeze tracking
    if (dit && dah) begin
      sq_nxt = SQ_SQUEEZED;
      if (mid_nxt == '0) begin
        sam_nxt = 1'b1;
      end
    end else if (!dit && !dah && sq_nxt == SQ_SQUEEZED) begin
      sq_nxt = SQ_RELEASED;
    end

    // element finished: alternate or stop
    if (elem_nxt == '0 && play_nxt != EL_NONE) begin
      again = (dit && dah) ||
              (ins_nxt && sq_nxt != SQ_RELEASED) ||
              (sq_nxt == SQ_RELEASED && flags.mode_b &&
               (!flags.mid_gate || sam_nxt));
      if (again) begin
        if (play_nxt == EL_DAH) begin
          play_nxt = EL_DIT;
          sched    = SCH_DIT;
        end else begin
          play_nxt = EL_DAH;
          sched    = SCH_DAH;
        end
      end else begin
        play_nxt = EL_NONE;
        if (flags.char_space && !dit && !dah) begin
          gap_nxt  = len2;
          kind_nxt = GAP_CHAR;
        end
      end
      ins_nxt = 1'b0;
      sq_nxt  = SQ_NONE;
      sam_nxt = 1'b0;
    end

    // start a new element, dah first
    if (play_nxt == EL_NONE) begin
      if (dah) begin
        play_nxt = EL_DAH;
        sched    = SCH_DAH;
      end else if (dit) begin
        play_nxt = EL_DIT;
        sched    = SCH_DIT;
      end
    end

    // paddle memories on a new press of the opposite paddle
    if (play_nxt == EL_DIT && !last_dah_nxt && dah && flags.dah_mem) begin
      ins_nxt = 1'b1;
    end
    if (play_nxt == EL_DAH && !last_dit_nxt && dit && flags.dit_mem) begin
      ins_nxt = 1'b1;
    end

    // drop a pending element during the gap when its memory is off
    if (gap_nxt != '0 && !dit && !dah &&
        ((play_nxt == EL_DIT && !flags.dit_mem) ||
         (play_nxt == EL_DAH && !flags.dah_mem))) begin
      play_nxt = EL_NONE;
      sched    = SCH_CANCEL;
    end

    // load element timers
    case (sched)
      SCH_CANCEL: begin
        beep_nxt = '0;
        mid_nxt  = '0;
        elem_nxt = '0;
      end
      SCH_DIT: begin
        beep_nxt = beep_dit;
        mid_nxt  = mid_dit;
        elem_nxt = len2;
      end
      SCH_DAH: begin
        beep_nxt = beep_dah;
        mid_nxt  = mid_dah;
        elem_nxt = len4;
      end
      default: begin
      end
    endcase

    last_dit_nxt = dit;
    last_dah_nxt = dah;
    key_nxt      = (beep_nxt != '0) && (gap_nxt == '0);
  end

  // state update on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r  <= 1'b0;
      last_dit_r <= 1'b0;
      last_dah_r <= 1'b0;
      play_r     <= EL_NONE;
      sq_r       <= SQ_NONE;
      sam_r      <= 1'b0;
      ins_r      <= 1'b0;
      mid_r      <= '0;
      beep_r     <= '0;
      elem_r     <= '0;
      gap_r      <= '0;
      kind_r     <= GAP_NONE;
    end else if (fire) begin
      started_r  <= 1'b1;
      last_dit_r <= last_dit_nxt;
      last_dah_r <= last_dah_nxt;
      play_r     <= play_nxt;
      sq_r       <= sq_nxt;
      sam_r      <= sam_nxt;
      ins_r      <= ins_nxt;
      mid_r      <= mid_nxt;
      beep_r     <= beep_nxt;
      elem_r     <= elem_nxt;
      gap_r      <= gap_nxt;
      kind_r     <= kind_nxt;
    end
  end

  // a running gap always has a kind
  a_gap_kind: assert property (@(posedge clk) disable iff (!rst_n)
    gap_r != '0 |-> kind_r != GAP_NONE)
    else $error("gap count running with no gap kind");

  // mid point never past the beep
  a_mid_le_beep: assert property (@(posedge clk) disable iff (!rst_n)
    mid_r <= beep_r)
    else $error("mid count above beep count");

  // state only moves on a transfer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(beep_r) && $stable(gap_r) && $stable(play_r))
    else $error("keyer state changed without a transfer");

endmodule
